FILE: rtl/core/bounded_priority_event_buffer_macros.svh
// Assertion macros for the buffer RTL.
`ifndef BOUNDED_PRIORITY_EVENT_BUFFER_MACROS_SVH
`define BOUNDED_PRIORITY_EVENT_BUFFER_MACROS_SVH
`ifndef SYNTH
`define BPEB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bpeb assertion failed");
`define BPEB_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bpeb forbidden condition seen");
`else
`define BPEB_ASSERT(lbl, clk, rstn, prop)
`define BPEB_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: rtl/core/bpeb_pkg.sv
`default_nettype none
package bpeb_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DEPTH    = CAPACITY + 1;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned CW       = $clog2(CAPACITY + 2);
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned TS_W     = 64;
  localparam int unsigned ARR_W    = 8;
  localparam int unsigned CFG_W    = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [PRIO_W-1:0] priority_req;
    logic [TS_W-1:0]   start_time;
    logic [TS_W-1:0]   stop_time;
  } in_req_t;

  typedef struct packed {
    logic [PRIO_W-1:0] out_priority;
    logic [TS_W-1:0]   out_start;
    logic [TS_W-1:0]   out_stop;
    logic              last;
  } out_rsp_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TS_W-1:0]   start;
    logic [TS_W-1:0]   stop;
    logic [ARR_W-1:0]  arrival;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_req_t;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_CHECK    = 6'b000010,
    S_SCAN_MIN = 6'b000100,
    S_SHIFT    = 6'b001000,
    S_SCAN_MAX = 6'b010000,
    S_EMIT     = 6'b100000
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/core/bpeb_ram.sv
`default_nettype none
module bpeb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/bpeb_obuf.sv
`default_nettype none
module bpeb_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bpeb_pkg::out_rsp_t  rsp_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bpeb_pkg::out_rsp_t  out_rsp_o
);

  import bpeb_pkg::*;

  logic     valid_q, valid_d;
  out_rsp_t data_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i && ready_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      data_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = data_q;

endmodule
`default_nettype wire

FILE: rtl/core/bpeb_ctrl.sv
`default_nettype none
`include "bounded_priority_event_buffer_macros.svh"
module bpeb_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bpeb_pkg::CW-1:0]    limit_i,
  input  logic                       in_valid_i,
  input  bpeb_pkg::in_req_t          in_req_i,
  output logic                       in_stall_o,
  output bpeb_pkg::ram_req_t         ram_req_o,
  input  bpeb_pkg::entry_t           ram_rdata_i,
  output logic                       push_o,
  output bpeb_pkg::out_rsp_t         push_rsp_o,
  input  logic                       push_ready_i
);

  import bpeb_pkg::*;

  state_e           state_q, state_d;
  logic [CW-1:0]    held_q, held_d;
  logic [ARR_W-1:0] arrival_q, arrival_d;
  logic [CW-1:0]    iss_q, iss_d;
  logic             pend_q, pend_d;
  logic             have_q, have_d;
  logic [CW-1:0]    remain_q, remain_d;
  logic [DEPTH-1:0] taken_q, taken_d;
  logic [AW-1:0]    pend_idx_q, pend_idx_d;
  logic [AW-1:0]    best_idx_q, best_idx_d;
  entry_t           best_q, best_d;
  logic             in_acc;
  logic             scan_done;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign scan_done  = (iss_q >= held_q) && !pend_q;

  assign push_rsp_o = '{out_priority: best_q.prio, out_start: best_q.start,
                        out_stop: best_q.stop, last: (remain_q == CW'(1))};

  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    arrival_d  = arrival_q;
    iss_d      = iss_q;
    pend_d     = pend_q;
    have_d     = have_q;
    remain_d   = remain_q;
    taken_d    = taken_q;
    pend_idx_d = pend_idx_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    ram_req_o  = '0;
    push_o     = 1'b0;

    if ((state_q == S_SCAN_MIN) || (state_q == S_SHIFT) || (state_q == S_SCAN_MAX)) begin
      if (iss_q < held_q) begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = iss_q[AW-1:0];
        iss_d           = iss_q + CW'(1);
        pend_d          = 1'b1;
        pend_idx_d      = iss_q[AW-1:0];
      end else begin
        pend_d = 1'b0;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_i.command == CMD_ADD) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = held_q[AW-1:0];
            ram_req_o.wdata = '{prio: in_req_i.priority_req, start: in_req_i.start_time,
                                stop: in_req_i.stop_time, arrival: arrival_q};
            arrival_d       = arrival_q + ARR_W'(1);
            held_d          = held_q + CW'(1);
            state_d         = S_CHECK;
          end else begin
            arrival_d = '0;
            if (held_q != '0) begin
              taken_d  = '0;
              remain_d = held_q;
              iss_d    = '0;
              pend_d   = 1'b0;
              have_d   = 1'b0;
              state_d  = S_SCAN_MAX;
            end
          end
        end
      end
      S_CHECK: begin
        if (held_q > limit_i) begin
          iss_d   = '0;
          pend_d  = 1'b0;
          state_d = S_SCAN_MIN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN_MIN: begin
        if (pend_q) begin
          if ((pend_idx_q == '0) || (ram_rdata_i.prio < best_q.prio)) begin
            best_d     = ram_rdata_i;
            best_idx_d = pend_idx_q;
          end
        end
        if (scan_done) begin
          iss_d   = CW'(best_idx_q) + CW'(1);
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (iss_q < held_q) begin
          pend_idx_d = AW'(iss_q - CW'(1));
        end
        if (pend_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = pend_idx_q;
          ram_req_o.wdata = ram_rdata_i;
        end
        if (scan_done) begin
          held_d  = held_q - CW'(1);
          state_d = S_CHECK;
        end
      end
      S_SCAN_MAX: begin
        if (pend_q && !taken_q[pend_idx_q]) begin
          if (!have_q || (ram_rdata_i.prio >= best_q.prio)) begin
            best_d     = ram_rdata_i;
            best_idx_d = pend_idx_q;
            have_d     = 1'b1;
          end
        end
        if (scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (push_ready_i) begin
          push_o              = 1'b1;
          taken_d[best_idx_q] = 1'b1;
          remain_d            = remain_q - CW'(1);
          if (remain_q == CW'(1)) begin
            held_d    = '0;
            arrival_d = '0;
            state_d   = S_IDLE;
          end else begin
            iss_d   = '0;
            pend_d  = 1'b0;
            have_d  = 1'b0;
            state_d = S_SCAN_MAX;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      held_q    <= '0;
      arrival_q <= '0;
      iss_q     <= '0;
      pend_q    <= 1'b0;
      have_q    <= 1'b0;
      remain_q  <= '0;
      taken_q   <= '0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      arrival_q <= arrival_d;
      iss_q     <= iss_d;
      pend_q    <= pend_d;
      have_q    <= have_d;
      remain_q  <= remain_d;
      taken_q   <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
  end

  `BPEB_NEVER(a_no_rw_clash, clk_i, rst_ni, ram_req_o.we && ram_req_o.re && (ram_req_o.waddr == ram_req_o.raddr))
  `BPEB_ASSERT(a_push_ready, clk_i, rst_ni, push_o |-> push_ready_i)
  `BPEB_ASSERT(a_idle_held, clk_i, rst_ni, (state_q == S_IDLE) |-> (held_q <= CW'(CAPACITY)))
  `BPEB_ASSERT(a_drain_remain, clk_i, rst_ni, ((state_q == S_SCAN_MAX) || (state_q == S_EMIT)) |-> ((remain_q != '0) && (remain_q <= held_q)))
  `BPEB_ASSERT(a_last_empties, clk_i, rst_ni, (push_o && (remain_q == CW'(1))) |=> (held_q == '0))

endmodule
`default_nettype wire

FILE: rtl/core/bounded_priority_event_buffer.sv
// Bounded priority event buffer.
// Requests enter on in_req_i under in_valid_i/in_stall_o. An add request stores
// an event (priority plus two 64-bit time stamps) in arrival order; when more
// events are held than cfg_wdata_i last allowed (0 acts as 1, above 16 as 16),
// the lowest-priority event, earliest among ties, is evicted. A drain request
// returns every held event on out_rsp_o, highest priority first and latest
// arrival first among ties, with last set on the final one, then empties the
// buffer. An empty drain returns nothing.
// An add writes the event and then checks the held count against the limit.
// Each eviction scans the event memory through its single read port for the
// victim and then shifts the entries above the victim down. A drain scans the
// memory once per result. Results pass through one output register, so a
// stalled receiver holds the current result while the next is prepared; the
// block takes no new request until a drain has pushed its last result into
// the output register.
// Reset empties the buffer and sets the limit to 16; the memory needs no clearing.
`default_nettype none
module bounded_priority_event_buffer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpeb_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bpeb_pkg::in_req_t            in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bpeb_pkg::out_rsp_t           out_rsp_o
);

  import bpeb_pkg::*;

  logic [CFG_W-1:0]   max_q;
  logic [CW-1:0]      limit;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               push;
  out_rsp_t           push_rsp;
  logic               push_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (max_q == '0) begin
      limit = CW'(1);
    end else if (32'(max_q) > CAPACITY) begin
      limit = CW'(CAPACITY);
    end else begin
      limit = CW'(max_q);
    end
  end

  bpeb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  bpeb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit),
    .in_valid_i   (in_valid_i),
    .in_req_i     (in_req_i),
    .in_stall_o   (in_stall_o),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (entry_t'(ram_rdata)),
    .push_o       (push),
    .push_rsp_o   (push_rsp),
    .push_ready_i (push_ready)
  );

  bpeb_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rsp_i       (push_rsp),
    .ready_o     (push_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire
